FILE: design/ssm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types and constants for the shear sort mesh block.
// ----------------------------------------------------------------------------
package ssm_pkg;

    // Width of the side configuration register
    localparam int SIDE_W  = 4;
    // Phase count fits in 3 bits for side up to 8; pass index is twice that
    localparam int PHASE_W = 3;
    localparam int PASS_W  = PHASE_W + 1;

    typedef logic [SIDE_W-1:0]  side_t;
    typedef logic [PHASE_W-1:0] phase_t;
    typedef logic [PASS_W-1:0]  pass_t;

    // Number of row/column phases: ceil(log2(side*side)) + 1
    function automatic phase_t phase_count(input side_t s);
        phase_t p;
        begin
            case (s)
                4'd1:    p = 3'd1;
                4'd2:    p = 3'd3;
                4'd3:    p = 3'd5;
                4'd4:    p = 3'd5;
                4'd5:    p = 3'd6;
                default: p = 3'd7;
            endcase
            return p;
        end
    endfunction

endpackage

FILE: design/ssm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssm_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module ssm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr_a,
    output logic [WIDTH-1:0]  rd_data_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [WIDTH-1:0]  rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and register both reads
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

FILE: design/shear_sort_square_mesh.sv
`timescale 1ns / 1ps
// Operation: side*side load beats at one per cycle while s_valid is high and cfg_we low,
//   then (2*P+1)*side*side*(side-1)/2 compare-swaps (P = ceil(log2(side*side))+1), run by
//   the single compare-swap unit on the store's one write port as read, compare and write
//   steps; readout reads, captures and holds each beat until taken. One run at a time.
// Reset: control state clears and side returns to 8; store contents stay undefined.
// ----------------------------------------------------------------------------
// shear_sort_square_mesh
// Loads a square of signed values, shear sorts it with one shared compare-swap
// unit over a RAM store, and streams the result out in snake order.
// ----------------------------------------------------------------------------
module shear_sort_square_mesh
    import ssm_pkg::*;
#(
    parameter int MAX_SIDE   = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [SIDE_W-1:0]            cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [DATA_WIDTH-1:0] s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0] m_sorted_value,
    output logic                         m_last
);

    localparam int CELLS  = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int IDX_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int CNT_W  = $clog2(MAX_SIDE + 1);
    localparam int CW     = CNT_W + 1;

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_CMP  = 3'd2;
    localparam logic [2:0] ST_WR2  = 3'd3;
    localparam logic [2:0] ST_ORD  = 3'd4;
    localparam logic [2:0] ST_OLD  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]       state_reg, state_next;
    side_t            side_reg, side_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] col_reg, col_next;
    logic [IDX_W-1:0] line_reg, line_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    pass_t            pass_reg, pass_next;
    logic             swap_reg, swap_next;
    logic [DATA_WIDTH-1:0] hold_reg, hold_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_last_reg, m_last_next;
    logic [DATA_WIDTH-1:0] out_reg, out_next;

    logic [CNT_W-1:0] eff_side;
    logic [IDX_W-1:0] side_m1;
    logic             col_pass;
    logic             up;
    logic [IDX_W-1:0] j_p1;
    logic [ADDR_W-1:0] addr_i, addr_j, addr_load, addr_snake;
    logic [IDX_W-1:0] snake_col;
    logic             swap;
    logic             last_pair;
    logic             last_cell;
    logic [CW-1:0]    j_lim, i_lim;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [DATA_WIDTH-1:0] rd_data_a, rd_data_b;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                    input logic [IDX_W-1:0] c);
        begin
            return ADDR_W'(int'(r) * MAX_SIDE + int'(c));
        end
    endfunction

    // Saturate the side register into 1..MAX_SIDE
    always_comb begin
        if (side_reg == '0) begin
            eff_side = CNT_W'(1);
        end else if (int'(side_reg) > MAX_SIDE) begin
            eff_side = CNT_W'(MAX_SIDE);
        end else begin
            eff_side = CNT_W'(side_reg);
        end
    end

    assign side_m1  = IDX_W'(eff_side - CNT_W'(1));
    assign col_pass = pass_reg[0];
    assign up       = col_pass | ~line_reg[0];
    assign j_p1     = j_reg + IDX_W'(1);

    // Pair addresses for the compare-swap unit
    assign addr_i = col_pass ? cell_addr(j_reg, line_reg) : cell_addr(line_reg, j_reg);
    assign addr_j = col_pass ? cell_addr(j_p1, line_reg)  : cell_addr(line_reg, j_p1);

    assign addr_load  = cell_addr(row_reg, col_reg);
    assign snake_col  = row_reg[0] ? (side_m1 - col_reg) : col_reg;
    assign addr_snake = cell_addr(row_reg, snake_col);
    assign last_cell  = (row_reg == side_m1) && (col_reg == side_m1);

    // Compare unit: order the pair ascending or descending
    assign swap = up ? ($signed(rd_data_a) > $signed(rd_data_b))
                     : ($signed(rd_data_a) < $signed(rd_data_b));

    // Bubble limits: j runs to s-2-i, i runs to s-2
    assign j_lim = CW'(eff_side) - CW'(i_reg) - CW'(1);
    assign i_lim = CW'(eff_side) - CW'(1);
    assign last_pair = (line_reg == side_m1)
                    && ((CW'(i_reg) + CW'(1)) >= i_lim)
                    && (pass_reg == {phase_count(side_t'(eff_side)), 1'b0});

    // Store port muxing
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = addr_load;
        wr_data = s_value;
        case (state_reg)
            ST_LOAD: begin
                wr_en = s_valid && !cfg_we;
            end
            ST_CMP: begin
                wr_en   = swap;
                wr_addr = addr_i;
                wr_data = rd_data_b;
            end
            ST_WR2: begin
                wr_en   = swap_reg;
                wr_addr = addr_j;
                wr_data = hold_reg;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign rd_addr_a = (state_reg == ST_ORD) ? addr_snake : addr_i;

    ssm_ram #(
        .WIDTH(DATA_WIDTH),
        .DEPTH(CELLS)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (addr_j),
        .rd_data_b (rd_data_b)
    );

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        side_next    = side_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        line_next    = line_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        pass_next    = pass_reg;
        swap_next    = swap_reg;
        hold_next    = hold_reg;
        m_valid_next = m_valid_reg;
        m_last_next  = m_last_reg;
        out_next     = out_reg;

        case (state_reg)
            ST_LOAD: begin
                // Take one beat per cycle in row-major order while s_valid is high and cfg_we is low
                if (cfg_we) begin
                    side_next = cfg_wdata;
                    row_next  = '0;
                    col_next  = '0;
                end else if (s_valid) begin
                    if (col_reg == side_m1) begin
                        col_next = '0;
                        if (row_reg == side_m1) begin
                            row_next  = '0;
                            line_next = '0;
                            i_next    = '0;
                            j_next    = '0;
                            pass_next = '0;
                            state_next = (eff_side == CNT_W'(1)) ? ST_ORD : ST_RD;
                        end else begin
                            row_next = row_reg + IDX_W'(1);
                        end
                    end else begin
                        col_next = col_reg + IDX_W'(1);
                    end
                end
            end
            ST_RD: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                // Write the first cell, hold the other value for the second write
                swap_next  = swap;
                hold_next  = rd_data_a;
                state_next = ST_WR2;
            end
            ST_WR2: begin
                // Advance j, then i, then line, then pass
                state_next = ST_RD;
                if ((CW'(j_reg) + CW'(1)) < j_lim) begin
                    j_next = j_p1;
                end else begin
                    j_next = '0;
                    if ((CW'(i_reg) + CW'(1)) < i_lim) begin
                        i_next = i_reg + IDX_W'(1);
                    end else begin
                        i_next = '0;
                        if (line_reg != side_m1) begin
                            line_next = line_reg + IDX_W'(1);
                        end else begin
                            line_next = '0;
                            pass_next = pass_reg + PASS_W'(1);
                        end
                    end
                end
                if (((CW'(j_reg) + CW'(1)) >= j_lim) && last_pair) begin
                    state_next = ST_ORD;
                end
            end
            ST_ORD: begin
                state_next = ST_OLD;
            end
            ST_OLD: begin
                // Capture the read into the output register
                out_next     = rd_data_a;
                m_last_next  = last_cell;
                m_valid_next = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                // Hold the beat until taken, then step the snake walk
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (last_cell) begin
                        row_next   = '0;
                        col_next   = '0;
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_ORD;
                        if (col_reg == side_m1) begin
                            col_next = '0;
                            row_next = row_reg + IDX_W'(1);
                        end else begin
                            col_next = col_reg + IDX_W'(1);
                        end
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            side_reg    <= side_t'(8);
            row_reg     <= '0;
            col_reg     <= '0;
            line_reg    <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            pass_reg    <= '0;
            swap_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            m_last_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            side_reg    <= side_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            line_reg    <= line_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            pass_reg    <= pass_next;
            swap_reg    <= swap_next;
            m_valid_reg <= m_valid_next;
            m_last_reg  <= m_last_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    assign s_ready        = (state_reg == ST_LOAD) && !cfg_we;
    assign m_valid        = m_valid_reg;
    assign m_last         = m_last_reg;
    assign m_sorted_value = out_reg;

endmodule
